@@ design/smm_pkg.sv @@
// Package for the sparse compressed-column matrix multiply unit: codes and default sizes.
package smm_pkg;
    localparam int MAX_ROWS_DEF     = 32;
    localparam int MAX_INNER_DEF    = 64;
    localparam int MAX_COLS_DEF     = 64;
    localparam int MAX_NONZEROS_DEF = 1024;

    typedef enum logic [2:0] {
        ACT_A_PTR   = 3'd0,
        ACT_A_ENTRY = 3'd1,
        ACT_B_PTR   = 3'd2,
        ACT_B_ENTRY = 3'd3,
        ACT_COMPUTE = 3'd4,
        ACT_RESTART = 3'd5
    } action_t;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;
endpackage

@@ design/smm_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/sparse_ccs_matrix_multiply_unit.sv @@
// Top level of the sparse compressed-column matrix multiply unit.
//
// Usage: drive action, slot, pointer_value, row_index and value and raise start
// while busy is low; the item is accepted at that clock edge and busy rises.
// Load actions (A/B column pointers, A/B entries) and restart output answer
// with a single acknowledge item (kind 0, last 1), registered from the ACK state.
// A compute item for column j of B walks every stored B entry of that column
// (one whose row lies outside the inner dimension is skipped); for each, it walks the
// A entries of the matching A column, one multiply-accumulate at a time
// through one shared 32x32 multiplier and one saturating 64-bit adder. It then
// scans rows 0..rows_in_use-1, one row per cycle, and emits every touched row
// (kind 1), followed by a column-end item (kind 2, last 1). Busy stays high
// from accept through the B walk, the A walks and the row scan; the
// column-end item is on the ports in the cycle busy falls, so the next item
// can be taken at the edge that ends it. A column outside cols_in_use holds
// busy for one cycle. Results leave on the result ports with out_strobe for
// one cycle; the receiver cannot stall. Reset clears control state,
// configuration to its defaults and the output pointer; the matrix stores are
// not cleared and must be loaded before use. Actions 6 and 7 are dropped.
module sparse_ccs_matrix_multiply_unit
    import smm_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int MAX_INNER    = MAX_INNER_DEF,
    parameter int MAX_COLS     = MAX_COLS_DEF,
    parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [10:0]        slot,
    input  logic [10:0]        pointer_value,
    input  logic [5:0]         row_index,
    input  logic signed [31:0] value,
    output logic               out_strobe,
    output logic [1:0]         kind,
    output logic [4:0]         out_row,
    output logic signed [63:0] out_value,
    output logic [5:0]         column_count,
    output logic [11:0]        column_start,
    output logic               last
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = $clog2(MAX_INNER + 1);
    localparam int BW = $clog2(MAX_COLS + 1);
    localparam int NW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int PW = $clog2(MAX_NONZEROS + 1);
    localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_ACK, S_BP0, S_BP1, S_BP2, S_BE_RD, S_BE_WAIT, S_BE_CHK,
        S_AP0, S_AP1, S_AP2, S_AE_RD, S_AE_WAIT, S_MUL, S_ACC,
        S_SCAN, S_END
    } state_t;

    state_t state_reg;

    // configuration
    logic [5:0] rows_cfg_reg;
    logic [6:0] inner_cfg_reg, cols_cfg_reg;
    logic       cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= 6'd32;
            inner_cfg_reg <= 7'd64;
            cols_cfg_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_ROWS:  rows_cfg_reg  <= pwdata[5:0];
                REG_INNER: inner_cfg_reg <= pwdata[6:0];
                REG_COLS:  cols_cfg_reg  <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS:  prdata = {26'd0, rows_cfg_reg};
            REG_INNER: prdata = {25'd0, inner_cfg_reg};
            REG_COLS:  prdata = {25'd0, cols_cfg_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // clamp registers to [1, MAX]
    logic [10:0] rows_lim, inner_lim, cols_lim;
    always_comb
    begin
        rows_lim  = (rows_cfg_reg == 6'd0) ? 11'd1 :
                    ({5'd0, rows_cfg_reg} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS)
                    : {5'd0, rows_cfg_reg};
        inner_lim = (inner_cfg_reg == 7'd0) ? 11'd1 :
                    ({4'd0, inner_cfg_reg} > 11'(MAX_INNER)) ? 11'(MAX_INNER)
                    : {4'd0, inner_cfg_reg};
        cols_lim  = (cols_cfg_reg == 7'd0) ? 11'd1 :
                    ({4'd0, cols_cfg_reg} > 11'(MAX_COLS)) ? 11'(MAX_COLS)
                    : {4'd0, cols_cfg_reg};
    end

    // memories
    logic          acs_we, bcs_we, ae_we, be_we;
    logic [AW-1:0] acs_raddr;
    logic [BW-1:0] bcs_raddr;
    logic [NW-1:0] ae_raddr, be_raddr;
    logic [10:0]   acs_rdata, bcs_rdata;
    logic [37:0]   ae_rdata, be_rdata;
    logic [AW-1:0] acs_waddr;
    logic [BW-1:0] bcs_waddr;
    logic [NW-1:0] ent_waddr;
    logic          accept;
    logic          act_ok;

    assign act_ok = (action == ACT_A_PTR) || (action == ACT_A_ENTRY) ||
                    (action == ACT_B_PTR) || (action == ACT_B_ENTRY) ||
                    (action == ACT_COMPUTE) || (action == ACT_RESTART);
    assign accept = start && !busy;
    assign acs_waddr = slot[AW-1:0];
    assign bcs_waddr = slot[BW-1:0];
    assign ent_waddr = slot[NW-1:0];
    assign acs_we = accept && action == ACT_A_PTR && {21'd0, slot} <= 32'(MAX_INNER);
    assign bcs_we = accept && action == ACT_B_PTR && {21'd0, slot} <= 32'(MAX_COLS);
    assign ae_we  = accept && action == ACT_A_ENTRY && {21'd0, slot} < 32'(MAX_NONZEROS);
    assign be_we  = accept && action == ACT_B_ENTRY && {21'd0, slot} < 32'(MAX_NONZEROS);

    smm_ram #(.WIDTH(11), .DEPTH(MAX_INNER + 1)) u_acs (
        .clk(clk), .we(acs_we), .waddr(acs_waddr), .wdata(pointer_value),
        .raddr(acs_raddr), .rdata(acs_rdata));
    smm_ram #(.WIDTH(11), .DEPTH(MAX_COLS + 1)) u_bcs (
        .clk(clk), .we(bcs_we), .waddr(bcs_waddr), .wdata(pointer_value),
        .raddr(bcs_raddr), .rdata(bcs_rdata));
    smm_ram #(.WIDTH(38), .DEPTH(MAX_NONZEROS)) u_ae (
        .clk(clk), .we(ae_we), .waddr(ent_waddr), .wdata({row_index, value}),
        .raddr(ae_raddr), .rdata(ae_rdata));
    smm_ram #(.WIDTH(38), .DEPTH(MAX_NONZEROS)) u_be (
        .clk(clk), .we(be_we), .waddr(ent_waddr), .wdata({row_index, value}),
        .raddr(be_raddr), .rdata(be_rdata));

    function automatic logic [PW-1:0] clip_ptr(input logic [10:0] p);
        if ({21'd0, p} > 32'(MAX_NONZEROS))
            return PW'(MAX_NONZEROS);
        return PW'(p);
    endfunction

    // datapath registers
    logic [10:0]        col_reg;
    logic [PW-1:0]      bi_reg, bend_reg, ai_reg, aend_reg;
    logic [5:0]         k_reg;
    logic signed [31:0] bv_reg;
    logic [RW-1:0]      ar_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        acc_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0] touched_reg;
    logic [10:0]        scan_reg;
    logic [5:0]         count_reg;
    logic [11:0]        total_reg;

    assign busy = (state_reg != S_IDLE);
    assign bcs_raddr = (state_reg == S_BP0) ? col_reg[BW-1:0] : BW'(col_reg + 11'd1);
    assign acs_raddr = (state_reg == S_AP0) ? AW'(k_reg) : AW'({5'd0, k_reg} + 11'd1);
    assign be_raddr  = bi_reg[NW-1:0];
    assign ae_raddr  = ai_reg[NW-1:0];

    // saturating add of the product into the selected row
    logic [63:0] add_a, add_sum, sat_sum;
    assign add_a   = acc_reg[ar_reg];
    assign add_sum = add_a + prod_reg;
    always_comb
    begin
        sat_sum = add_sum;
        if (!add_a[63] && !prod_reg[63] && add_sum[63]) sat_sum = SAT_MAX;
        if (add_a[63] && prod_reg[63] && !add_sum[63])  sat_sum = SAT_MIN;
    end

    logic [RW-1:0] scan_row;
    assign scan_row = scan_reg[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            touched_reg  <= '0;
            total_reg    <= 12'd0;
            out_strobe   <= 1'b0;
            kind         <= KIND_ACK;
            out_row      <= 5'd0;
            out_value    <= 64'sd0;
            column_count <= 6'd0;
            column_start <= 12'd0;
            last         <= 1'b0;
            count_reg    <= 6'd0;
            scan_reg     <= 11'd0;
            col_reg      <= 11'd0;
        end
        else
        begin
            out_strobe <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && act_ok)
                    begin
                        col_reg <= slot;
                        if (action == ACT_RESTART)
                            total_reg <= 12'd0;
                        if (action == ACT_COMPUTE)
                        begin
                            count_reg <= 6'd0;
                            scan_reg  <= 11'd0;
                            state_reg <= (slot >= cols_lim) ? S_END : S_BP0;
                        end
                        else
                        begin
                            state_reg <= S_ACK;
                        end
                    end
                end
                S_ACK:
                begin
                    out_strobe   <= 1'b1;
                    kind         <= KIND_ACK;
                    out_row      <= 5'd0;
                    out_value    <= 64'sd0;
                    column_count <= 6'd0;
                    column_start <= 12'd0;
                    last         <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_BP0: state_reg <= S_BP1;   // start pointer read issued
                S_BP1:
                begin
                    bi_reg    <= clip_ptr(bcs_rdata);
                    state_reg <= S_BP2;
                end
                S_BP2:
                begin
                    bend_reg  <= clip_ptr(bcs_rdata);
                    state_reg <= S_BE_RD;
                end
                S_BE_RD:
                    state_reg <= (bi_reg < bend_reg) ? S_BE_WAIT : S_SCAN;
                S_BE_WAIT: state_reg <= S_BE_CHK;
                S_BE_CHK:
                begin
                    k_reg  <= be_rdata[37:32];
                    bv_reg <= be_rdata[31:0];
                    bi_reg <= bi_reg + PW'(1);
                    // skip a B entry whose row lies outside the inner dimension
                    state_reg <= ({5'd0, be_rdata[37:32]} >= inner_lim) ? S_BE_RD : S_AP0;
                end
                S_AP0: state_reg <= S_AP1;
                S_AP1:
                begin
                    ai_reg    <= clip_ptr(acs_rdata);
                    state_reg <= S_AP2;
                end
                S_AP2:
                begin
                    aend_reg  <= clip_ptr(acs_rdata);
                    state_reg <= S_AE_RD;
                end
                S_AE_RD:
                    state_reg <= (ai_reg < aend_reg) ? S_AE_WAIT : S_BE_RD;
                S_AE_WAIT: state_reg <= S_MUL;
                S_MUL:
                begin
                    ai_reg <= ai_reg + PW'(1);
                    ar_reg <= ae_rdata[32 +: RW];
                    // drop an A entry whose row lies outside the product
                    if ({5'd0, ae_rdata[37:32]} >= rows_lim)
                        state_reg <= S_AE_RD;
                    else
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_AE_RD;
                end
                S_SCAN:
                begin
                    if (scan_reg >= rows_lim)
                    begin
                        state_reg <= S_END;
                    end
                    else
                    begin
                        if (touched_reg[scan_row])
                        begin
                            out_strobe   <= 1'b1;
                            kind         <= KIND_ENTRY;
                            out_row      <= 5'(scan_reg);
                            out_value    <= acc_reg[scan_row];
                            column_count <= 6'd0;
                            column_start <= 12'd0;
                            last         <= 1'b0;
                            count_reg    <= count_reg + 6'd1;
                            touched_reg[scan_row] <= 1'b0;
                        end
                        scan_reg <= scan_reg + 11'd1;
                    end
                end
                S_END:
                begin
                    out_strobe   <= 1'b1;
                    kind         <= KIND_END;
                    out_row      <= 5'd0;
                    out_value    <= 64'sd0;
                    column_count <= count_reg;
                    column_start <= total_reg;
                    last         <= 1'b1;
                    total_reg    <= total_reg + {6'd0, count_reg};
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_ACC)
                touched_reg[ar_reg] <= 1'b1;
        end
    end

    // product register, accumulators (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= 64'(bv_reg) * 64'(signed'(ae_rdata[31:0]));
        if (state_reg == S_ACC)
            acc_reg[ar_reg] <= touched_reg[ar_reg] ? sat_sum : prod_reg;
    end

    property p_ack_one_cycle;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACK) |=> (out_strobe && last && kind == KIND_ACK);
    endproperty
    a_ack_one_cycle: assert property (p_ack_one_cycle) else $error("ack missing");

    property p_last_ends_busy;
        @(posedge clk) disable iff (!rst_n)
        (out_strobe && last) |-> !busy;
    endproperty
    a_last_ends_busy: assert property (p_last_ends_busy) else $error("busy after last");

    property p_end_clears_touched;
        @(posedge clk) disable iff (!rst_n)
        (out_strobe && kind == KIND_END) |-> (touched_reg == '0);
    endproperty
    a_end_clears: assert property (p_end_clears_touched) else $error("rows left touched");
endmodule
